### rtl/note_arpeggiator_sequencer_unit_assert.svh
// Assertion macros for the arpeggiator sequencer RTL.
`ifndef NOTE_ARPEGGIATOR_SEQUENCER_UNIT_ASSERT_SVH
`define NOTE_ARPEGGIATOR_SEQUENCER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ARP_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ARP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARP_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ARP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/arp_pkg.sv
// Shared types, constants and functions of the arpeggiator sequencer.
`timescale 1ns / 1ps
package arp_pkg;

    localparam int HELD_NOTES_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_STEPS_DEF   = 8;

    localparam int PITCH_W    = 7;
    localparam int LEVEL_W    = 7;
    localparam int COUNT_W    = 12;
    localparam int LEN_W      = 34;
    localparam int FRAC_W     = 16;
    localparam int RAND_W     = 32;
    localparam int PHASE_W    = 36;
    localparam int EFF_W      = 35;
    localparam int POS_W      = 32;
    localparam int ENTRY_W    = 15;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;
    localparam int MOD_DIGITS = 4;
    localparam int SWING_SHIFT = 17;
    localparam int GATE_SHIFT  = 16;
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    localparam logic [LEN_W-1:0]  LEN_RST   = 34'd1572864000;
    localparam logic [FRAC_W-1:0] GATE_RST  = 16'd32768;
    localparam logic [FRAC_W-1:0] SWING_RST = 16'd0;
    localparam logic [RAND_W-1:0] RAND_RST  = 32'd1;

    localparam logic [KIND_W-1:0] PAT_UP     = 3'd0;
    localparam logic [KIND_W-1:0] PAT_DOWN   = 3'd1;
    localparam logic [KIND_W-1:0] PAT_UPDOWN = 3'd2;
    localparam logic [KIND_W-1:0] PAT_DOWNUP = 3'd3;
    localparam logic [KIND_W-1:0] PAT_RANDOM = 3'd4;

    typedef enum logic [1:0] {
        MODE_ON      = 2'd0,
        MODE_OFF     = 2'd1,
        MODE_ALL_OFF = 2'd2,
        MODE_ADVANCE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED = 3'd0,
        REG_KIND    = 3'd1,
        REG_LENGTH  = 3'd2,
        REG_GATE    = 3'd3,
        REG_SWING   = 3'd4,
        REG_SEED    = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_INSERT = 3'd1,
        OP_UPDATE = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [PITCH_W-1:0] pitch;
        logic [LEVEL_W-1:0] level;
    } note_t;

    typedef struct packed {
        cell_op_t           op;
        logic [PITCH_W-1:0] pitch;
        logic [LEVEL_W-1:0] level;
    } cell_cmd_t;

    typedef struct packed {
        logic               valid;
        logic               is_on;
        logic [PITCH_W-1:0] note;
        logic [LEVEL_W-1:0] velocity;
    } event_t;

    function automatic logic [RAND_W-1:0] xorshift32(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] x;
        x = s ^ (s << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        return x;
    endfunction

endpackage

### rtl/note_arpeggiator_sequencer_unit.sv
// Top level of the arpeggiator sequencer: note chain, step sequencer, event queue.
//
// channel   direction  handshake             payload
// in        sink       in_valid / in_ready   mode, note_number, note_velocity, sample_count
// out       source     out_valid / out_ready event_valid, event_is_on, event_note, event_velocity
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Note commands update the cell chain while the sequencer stays idle. An advance pops a
// queued event through the pop and emit states; otherwise each step runs timing and
// selection, with passes through the shared remainder unit (up to three for random).
// One request at a time; a finished result waits in the output register.
// Reset clears the chain, queue pointers and sequencer state; queue RAM is not cleared.
`timescale 1ns / 1ps
`include "note_arpeggiator_sequencer_unit_assert.svh"
module note_arpeggiator_sequencer_unit import arp_pkg::*; #(
    parameter int HELD_NOTES  = HELD_NOTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [PITCH_W-1:0]    note_number,
    input  logic [LEVEL_W-1:0]    note_velocity,
    input  logic [COUNT_W-1:0]    sample_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  event_valid,
    output logic                  event_is_on,
    output logic [PITCH_W-1:0]    event_note,
    output logic [LEVEL_W-1:0]    event_velocity,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HN_W = $clog2(HELD_NOTES);
    localparam int CNT_W = $clog2(HELD_NOTES + 1);
    localparam int DV_W = $clog2(2 * HELD_NOTES);
    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ST_W = $clog2(MAX_STEPS + 1);
    localparam int SWP_W = LEN_W + FRAC_W;
    localparam int GP_W = EFF_W + FRAC_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_T1   = 11'b00000000010,
        S_T2   = 11'b00000000100,
        S_T3   = 11'b00000001000,
        S_ADV  = 11'b00000010000,
        S_LOOP = 11'b00000100000,
        S_PICK = 11'b00001000000,
        S_MOD  = 11'b00010000000,
        S_SEL  = 11'b00100000000,
        S_POP  = 11'b01000000000,
        S_EMIT = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                enabled_reg, enabled_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [FRAC_W-1:0]   gate_frac_reg, gate_frac_next;
    logic [FRAC_W-1:0]   swing_reg, swing_next;
    logic [RAND_W-1:0]   rand_reg, rand_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [QA_W-1:0]     head_reg, head_next;
    logic [QF_W-1:0]     fill_reg, fill_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                gate_reg, gate_next;
    logic                parity_reg, parity_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                snd_valid_reg, snd_valid_next;
    logic [PITCH_W-1:0]  snd_pitch_reg, snd_pitch_next;
    logic                tfirst_reg, tfirst_next;
    logic [ST_W-1:0]     steps_reg, steps_next;
    logic [1:0]          tries_reg, tries_next;
    logic                pop_mode_reg, pop_mode_next;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  adv_cnt_reg, adv_cnt_next;
    logic [SWP_W-1:0]    swp_reg, swp_next;
    logic [EFF_W-1:0]    eff_reg, eff_next;
    logic [EFF_W-1:0]    gend_reg, gend_next;
    event_t              res_reg, res_next;
    event_t              out_reg, out_next;

    logic                in_fire, cfg_fire;
    cell_cmd_t           cmd;
    note_t               cell_note [HELD_NOTES];
    logic                cell_open [HELD_NOTES];
    logic                cell_hit  [HELD_NOTES];
    note_t               lnote [HELD_NOTES];
    logic                lopen [HELD_NOTES];
    logic                lhit  [HELD_NOTES];
    note_t               rnote [HELD_NOTES];
    logic                any_hit;

    logic                push_en, q_we;
    logic [ENTRY_W-1:0]  push_data, q_rdata;
    logic [QA_W:0]       wsum;
    logic [QA_W-1:0]     waddr;

    logic                mod_start, mod_busy;
    logic [POS_W-1:0]    mod_dividend;
    logic [DV_W-1:0]     mod_divisor, mod_rem;
    logic [DV_W-1:0]     n_dv, cyc, up, idx_full;
    logic [HN_W-1:0]     sel_idx;
    note_t               sel_note;
    logic                need_mod, is_random, retry;
    logic [RAND_W-1:0]   rand_step;
    logic [PHASE_W:0]    adv_sum;
    logic [PHASE_W-1:0]  phase_sat, eff_ph, gend_ph;
    logic [GP_W-1:0]     gate_prod;

    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmd = '{op: OP_HOLD, pitch: note_number, level: note_velocity};
        if (in_fire)
        begin
            case (mode_t'(mode))
                MODE_ON:
                begin
                    if (any_hit)
                    begin
                        cmd.op = OP_UPDATE;
                    end
                    else if (count_reg < CNT_W'(HELD_NOTES))
                    begin
                        cmd.op = OP_INSERT;
                    end
                end
                MODE_OFF:     cmd.op = OP_REMOVE;
                MODE_ALL_OFF: cmd.op = OP_CLEAR;
                default:      cmd.op = OP_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < HELD_NOTES; g++)
    begin : g_chain
        if (g == 0)
        begin : g_first
            assign lnote[g] = '0;
            assign lopen[g] = 1'b0;
            assign lhit[g]  = 1'b0;
        end
        else
        begin : g_mid
            assign lnote[g] = cell_note[g-1];
            assign lopen[g] = cell_open[g-1];
            assign lhit[g]  = cell_hit[g-1];
        end
        if (g == HELD_NOTES - 1)
        begin : g_last
            assign rnote[g] = '0;
        end
        else
        begin : g_inner
            assign rnote[g] = cell_note[g+1];
        end
        arp_cell u_note_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_note  (lnote[g]),
            .left_open  (lopen[g]),
            .left_hit   (lhit[g]),
            .right_note (rnote[g]),
            .note       (cell_note[g]),
            .open       (cell_open[g]),
            .hit        (cell_hit[g])
        );
    end

    always_comb
    begin
        any_hit = 1'b0;
        for (int k = 0; k < HELD_NOTES; k++)
        begin
            if (cell_note[k].valid && (cell_note[k].pitch == note_number))
            begin
                any_hit = 1'b1;
            end
        end
    end

    assign wsum  = (QA_W+1)'(head_reg) + (QA_W+1)'(fill_reg);
    assign waddr = (wsum >= (QA_W+1)'(QUEUE_DEPTH)) ?
                   QA_W'(wsum - (QA_W+1)'(QUEUE_DEPTH)) : QA_W'(wsum);
    assign q_we  = push_en && (fill_reg < QF_W'(QUEUE_DEPTH));

    arp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (waddr),
        .wdata (push_data),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    arp_mod #(
        .DIV_W (DV_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    assign n_dv      = DV_W'(count_reg);
    assign cyc       = (count_reg > CNT_W'(1)) ? (n_dv + n_dv - DV_W'(2)) : DV_W'(1);
    assign up        = (mod_rem < n_dv) ? mod_rem : (cyc - mod_rem);
    assign is_random = (kind_reg == PAT_RANDOM) && (count_reg > CNT_W'(1));
    assign need_mod  = (kind_reg < PAT_RANDOM) || is_random;
    assign rand_step = xorshift32(rand_reg);

    always_comb
    begin
        case (kind_reg)
            PAT_UP:     idx_full = mod_rem;
            PAT_DOWN:   idx_full = n_dv - DV_W'(1) - mod_rem;
            PAT_UPDOWN: idx_full = up;
            PAT_DOWNUP: idx_full = n_dv - DV_W'(1) - up;
            PAT_RANDOM: idx_full = is_random ? mod_rem : '0;
            default:    idx_full = '0;
        endcase
    end

    assign sel_idx  = idx_full[HN_W-1:0];
    assign sel_note = cell_note[sel_idx];
    assign retry    = is_random && snd_valid_reg && (sel_note.pitch == snd_pitch_reg) &&
                      (tries_reg < 2'd2);

    assign adv_sum   = {1'b0, phase_reg} + (PHASE_W+1)'({adv_cnt_reg, 16'b0});
    assign phase_sat = adv_sum[PHASE_W] ? '1 : adv_sum[PHASE_W-1:0];
    assign eff_ph    = PHASE_W'(eff_reg);
    assign gend_ph   = PHASE_W'(gend_reg);
    assign gate_prod = GP_W'(eff_reg) * GP_W'(gate_frac_reg);

    always_comb
    begin
        state_next     = state_reg;
        enabled_next   = enabled_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        gate_frac_next = gate_frac_reg;
        swing_next     = swing_reg;
        rand_next      = rand_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        gate_next      = gate_reg;
        parity_next    = parity_reg;
        pos_next       = pos_reg;
        snd_valid_next = snd_valid_reg;
        snd_pitch_next = snd_pitch_reg;
        tfirst_next    = tfirst_reg;
        steps_next     = steps_reg;
        tries_next     = tries_reg;
        pop_mode_next  = pop_mode_reg;
        out_valid_next = out_valid_reg;
        adv_cnt_next   = adv_cnt_reg;
        swp_next       = swp_reg;
        eff_next       = eff_reg;
        gend_next      = gend_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        push_en        = 1'b0;
        push_data      = '0;
        mod_start      = 1'b0;
        mod_dividend   = pos_reg;
        mod_divisor    = ((kind_reg == PAT_UPDOWN) || (kind_reg == PAT_DOWNUP)) ? cyc : n_dv;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (mode_t'(mode))
                        MODE_ON:
                        begin
                            if (!any_hit && (count_reg < CNT_W'(HELD_NOTES)))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_OFF:
                        begin
                            if (any_hit)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        MODE_ALL_OFF:
                        begin
                            count_next = '0;
                        end
                        MODE_ADVANCE:
                        begin
                            adv_cnt_next  = sample_count;
                            steps_next    = '0;
                            pop_mode_next = 1'b0;
                            res_next      = '0;
                            if (fill_reg != '0)
                            begin
                                state_next = S_POP;
                            end
                            else if (!enabled_reg)
                            begin
                                state_next = S_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                if (gate_reg && snd_valid_reg)
                                begin
                                    res_next.valid = 1'b1;
                                    res_next.note  = snd_pitch_reg;
                                    snd_valid_next = 1'b0;
                                end
                                gate_next  = 1'b0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                tfirst_next = 1'b1;
                                state_next  = S_T1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_T1:
            begin
                swp_next   = SWP_W'(len_reg) * SWP_W'(swing_reg);
                state_next = S_T2;
            end
            S_T2:
            begin
                eff_next = parity_reg ?
                           EFF_W'(len_reg) + EFF_W'(swp_reg[SWP_W-1:SWING_SHIFT]) :
                           EFF_W'(len_reg);
                state_next = S_T3;
            end
            S_T3:
            begin
                gend_next  = gate_prod[GP_W-1:GATE_SHIFT];
                state_next = tfirst_reg ? S_ADV : S_PICK;
            end
            S_ADV:
            begin
                tfirst_next = 1'b0;
                phase_next  = phase_sat;
                if (gate_reg && (phase_sat >= gend_ph))
                begin
                    gate_next = 1'b0;
                    push_en   = 1'b1;
                    push_data = {1'b0, snd_pitch_reg, 7'd0};
                end
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if ((steps_reg < ST_W'(MAX_STEPS)) && (phase_reg >= eff_ph))
                begin
                    steps_next = steps_reg + ST_W'(1);
                    tries_next = '0;
                    if (gate_reg)
                    begin
                        gate_next = 1'b0;
                        push_en   = 1'b1;
                        push_data = {1'b0, snd_pitch_reg, 7'd0};
                    end
                    phase_next  = phase_reg - eff_ph;
                    parity_next = !parity_reg;
                    state_next  = S_T1;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_PICK:
            begin
                if (need_mod)
                begin
                    if (is_random)
                    begin
                        rand_next    = rand_step;
                        mod_dividend = rand_step;
                    end
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_SEL;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (retry)
                begin
                    tries_next = tries_reg + 2'd1;
                    state_next = S_PICK;
                end
                else
                begin
                    if (kind_reg < PAT_RANDOM)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    snd_pitch_next = sel_note.pitch;
                    snd_valid_next = 1'b1;
                    if (phase_reg < gend_ph)
                    begin
                        gate_next = 1'b1;
                        push_en   = 1'b1;
                        push_data = {1'b1, sel_note.pitch, sel_note.level};
                    end
                    state_next = S_LOOP;
                end
            end
            S_POP:
            begin
                pop_mode_next = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (pop_mode_reg && (fill_reg != '0))
                    begin
                        out_next.valid    = 1'b1;
                        out_next.is_on    = q_rdata[14];
                        out_next.note     = q_rdata[13:7];
                        out_next.velocity = q_rdata[6:0];
                        head_next = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : head_reg + QA_W'(1);
                        fill_next = fill_reg - QF_W'(1);
                    end
                    else if (pop_mode_reg)
                    begin
                        out_next = '0;
                    end
                    else
                    begin
                        out_next = res_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (q_we)
        begin
            fill_next = fill_reg + QF_W'(1);
        end

        if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ENABLED:
                begin
                    if (enabled_reg && !cfg_data[0])
                    begin
                        phase_next     = '0;
                        gate_next      = 1'b0;
                        parity_next    = 1'b0;
                        pos_next       = '0;
                        snd_valid_next = 1'b0;
                        snd_pitch_next = '0;
                        head_next      = '0;
                        fill_next      = '0;
                    end
                    enabled_next = cfg_data[0];
                end
                REG_KIND:   kind_next      = cfg_data[KIND_W-1:0];
                REG_LENGTH: len_next       = cfg_data[LEN_W-1:0];
                REG_GATE:   gate_frac_next = cfg_data[FRAC_W-1:0];
                REG_SWING:  swing_next     = cfg_data[FRAC_W-1:0];
                REG_SEED:
                begin
                    rand_next = (cfg_data[RAND_W-1:0] == '0) ? RAND_RST : cfg_data[RAND_W-1:0];
                end
                default:
                begin
                    enabled_next = enabled_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enabled_reg   <= 1'b0;
            kind_reg      <= PAT_UP;
            len_reg       <= LEN_RST;
            gate_frac_reg <= GATE_RST;
            swing_reg     <= SWING_RST;
            rand_reg      <= RAND_RST;
            count_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            gate_reg      <= 1'b0;
            parity_reg    <= 1'b0;
            pos_reg       <= '0;
            snd_valid_reg <= 1'b0;
            snd_pitch_reg <= '0;
            tfirst_reg    <= 1'b0;
            steps_reg     <= '0;
            tries_reg     <= '0;
            pop_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            kind_reg      <= kind_next;
            len_reg       <= len_next;
            gate_frac_reg <= gate_frac_next;
            swing_reg     <= swing_next;
            rand_reg      <= rand_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            gate_reg      <= gate_next;
            parity_reg    <= parity_next;
            pos_reg       <= pos_next;
            snd_valid_reg <= snd_valid_next;
            snd_pitch_reg <= snd_pitch_next;
            tfirst_reg    <= tfirst_next;
            steps_reg     <= steps_next;
            tries_reg     <= tries_next;
            pop_mode_reg  <= pop_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adv_cnt_reg <= adv_cnt_next;
        swp_reg     <= swp_next;
        eff_reg     <= eff_next;
        gend_reg    <= gend_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign event_valid    = out_reg.valid;
    assign event_is_on    = out_reg.is_on;
    assign event_note     = out_reg.note;
    assign event_velocity = out_reg.velocity;

    `ARP_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= QF_W'(QUEUE_DEPTH), "queue overfilled")
    `ARP_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(HELD_NOTES), "note count too high")
    `ARP_ASSERT_ALWAYS(a_chain_count, clk, rst_n, cell_note[0].valid == (count_reg != '0), "chain and count disagree")
    `ARP_ASSERT_ALWAYS(a_gate_sounding, clk, rst_n, !gate_reg || snd_valid_reg, "gate open with no sounding note")
    `ARP_ASSERT_ALWAYS(a_hit_chain, clk, rst_n, any_hit == cell_hit[HELD_NOTES-1], "match chain disagrees")
    `ARP_ASSERT_NEXT(a_note_cmd_quick, clk, rst_n, in_fire && (mode != MODE_ADVANCE), in_ready, "note request did not complete in one cycle")

endmodule

### rtl/arp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/arp_cell.sv
// One cell of the pitch-sorted held-note chain.
`timescale 1ns / 1ps
module arp_cell import arp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  note_t     left_note,
    input  logic      left_open,
    input  logic      left_hit,
    input  note_t     right_note,
    output note_t     note,
    output logic      open,
    output logic      hit
);

    note_t note_reg;
    note_t note_next;
    logic  match;

    assign open  = !note_reg.valid || (note_reg.pitch > cmd.pitch);
    assign match = note_reg.valid && (note_reg.pitch == cmd.pitch);
    assign hit   = left_hit | match;
    assign note  = note_reg;

    always_comb
    begin
        note_next = note_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (open && left_open)
                begin
                    note_next = left_note;
                end
                else if (open)
                begin
                    note_next = '{valid: 1'b1, pitch: cmd.pitch, level: cmd.level};
                end
            end
            OP_UPDATE:
            begin
                if (match)
                begin
                    note_next.level = cmd.level;
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    note_next = right_note;
                end
            end
            OP_CLEAR:
            begin
                note_next.valid = 1'b0;
            end
            default:
            begin
                note_next = note_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_reg <= '0;
        end
        else
        begin
            note_reg <= note_next;
        end
    end

endmodule

### rtl/arp_mod.sv
// Iterative remainder unit, four dividend bits per cycle.
`timescale 1ns / 1ps
module arp_mod import arp_pkg::*; #(
    parameter int DIV_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] rem
);

    localparam int STEPS = POS_W / MOD_DIGITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [POS_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   r;
    logic [POS_W-1:0] q;

    always_comb
    begin
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int k = 0; k < MOD_DIGITS; k++)
        begin
            r = {r[DIV_W-1:0], q[POS_W-1]};
            q = {q[POS_W-2:0], 1'b0};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = q;
            rem_next = r[DIV_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule
